// ----- rtl/wrrp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wrrp_pkg
// Shared constants, types and helper functions of the weighted round-robin
// picker.
// ----------------------------------------------------------------------------
package wrrp_pkg;

  localparam int MAX_SERVERS = 8;
  localparam int WEIGHT_BITS = 8;

  localparam int WORD_W   = 64;
  localparam int COUNT_W  = 4;
  localparam int INDEX_W  = 3;
  localparam int DATA_W   = 64;
  localparam int ADDR_W   = 4;
  localparam int IDX_W    = $clog2(MAX_SERVERS);
  localparam int CNT_W    = $clog2(MAX_SERVERS + 1);
  localparam int CW_W     = WEIGHT_BITS + 1;
  localparam int PAD_W    = MAX_SERVERS * WEIGHT_BITS;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic REG_SERVER_COUNT = 1'b0;
  localparam logic REG_WEIGHT_WORD  = 1'b1;

  typedef struct packed {
    logic rewind;
  } q_item_t;

  typedef struct packed {
    logic                   start;
    logic [WEIGHT_BITS-1:0] a;
    logic [WEIGHT_BITS-1:0] b;
  } gcd_req_t;

  typedef struct packed {
    logic                   done;
    logic [WEIGHT_BITS-1:0] result;
  } gcd_rsp_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SCAN,
    B_GCD,
    B_FIX,
    B_SEARCH
  } back_state_t;

  function automatic logic [CNT_W-1:0] pool_size(input logic [COUNT_W-1:0] sc);
    logic [CNT_W-1:0] n;
    if (sc == '0) begin
      n = CNT_W'(1);
    end else if (sc > COUNT_W'(MAX_SERVERS)) begin
      n = CNT_W'(MAX_SERVERS);
    end else begin
      n = CNT_W'(sc);
    end
    return n;
  endfunction

  function automatic logic [WEIGHT_BITS-1:0] weight_of(input logic [WORD_W-1:0] word,
                                                       input logic [IDX_W-1:0] idx);
    logic [PAD_W+WORD_W-1:0] ext;
    ext = {{PAD_W{1'b0}}, word};
    return ext[idx*WEIGHT_BITS +: WEIGHT_BITS];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/wrrp_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wrrp_front
// Accepts request words, tags each with its rewind flag and holds them in a
// short queue for the sequencer.
// ----------------------------------------------------------------------------
module wrrp_front import wrrp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_ready,
  input  logic    restart,
  output logic    q_valid,
  output q_item_t q_item,
  input  logic    q_pop
);

  q_item_t           slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              push;
  logic              pop;

  assign req_ready = (fill != QCNT_W'(QUEUE_DEPTH));
  assign q_valid   = (fill != '0);
  assign q_item    = slots[rd_ptr];
  assign push      = req_valid && req_ready;
  assign pop       = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr].rewind <= restart;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/wrrp_gcd.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wrrp_gcd
// Subtractive greatest common divisor unit, one subtraction per cycle.
// ----------------------------------------------------------------------------
module wrrp_gcd import wrrp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  gcd_req_t req,
  output gcd_rsp_t rsp
);

  logic                   busy;
  logic [WEIGHT_BITS-1:0] x;
  logic [WEIGHT_BITS-1:0] y;

  assign rsp.done   = busy && (x == y);
  assign rsp.result = x;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
    end else if (busy && (x == y)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      x <= req.a;
      y <= req.b;
    end else if (busy) begin
      if (x > y) begin
        x <= x - y;
      end else if (y > x) begin
        y <= y - x;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/wrrp_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wrrp_back
// Pick sequencer: derives divisor and largest weight, walks the cursor one
// server per cycle unless an untaken pick blocks; holds the pick until taken.
// ----------------------------------------------------------------------------
module wrrp_back import wrrp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_touch,
  input  logic [COUNT_W-1:0] server_count,
  input  logic [WORD_W-1:0]  weight_word,
  input  logic               q_valid,
  input  q_item_t            q_item,
  output logic               q_pop,
  output gcd_req_t           gcd_req,
  input  gcd_rsp_t           gcd_rsp,
  output logic               pick_valid,
  input  logic               pick_ready,
  output logic [INDEX_W-1:0] server_index,
  output logic               none_eligible
);

  back_state_t            state, state_next;
  logic                   started, started_next;
  logic                   first, first_next;
  logic [IDX_W-1:0]       cursor, cursor_next;
  logic [CW_W-1:0]        cw, cw_next;
  logic [WEIGHT_BITS-1:0] divisor, divisor_next;
  logic [WEIGHT_BITS-1:0] largest, largest_next;
  logic [IDX_W-1:0]       scan_idx, scan_idx_next;
  logic                   pick_valid_next;
  logic [INDEX_W-1:0]     server_index_next;
  logic                   none_eligible_next;

  logic [IDX_W-1:0]       last;
  logic [WEIGHT_BITS-1:0] scan_w;
  logic                   scan_last;
  logic [IDX_W-1:0]       s_step;
  logic [CW_W-1:0]        cw_step;
  logic                   hit;
  logic                   slot_free;

  assign last      = IDX_W'(pool_size(server_count) - CNT_W'(1));
  assign scan_w    = weight_of(weight_word, scan_idx);
  assign scan_last = (scan_idx == last);
  assign s_step    = first ? '0 : ((cursor == last) ? '0 : cursor + IDX_W'(1));
  assign slot_free = !pick_valid || pick_ready;

  always_comb begin
    cw_step = cw;
    if (s_step == '0) begin
      if (cw <= CW_W'(divisor)) begin
        cw_step = CW_W'(largest);
      end else begin
        cw_step = cw - CW_W'(divisor);
      end
    end
  end

  assign hit = (CW_W'(weight_of(weight_word, s_step)) >= cw_step);

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (q_valid) begin
          state_next = (q_item.rewind || !started) ? B_SCAN : B_SEARCH;
        end
      end
      B_SCAN: begin
        if ((scan_w != '0) && (divisor != '0)) begin
          state_next = B_GCD;
        end else if (scan_last) begin
          state_next = B_FIX;
        end
      end
      B_GCD: begin
        if (gcd_rsp.done) begin
          state_next = scan_last ? B_FIX : B_SCAN;
        end
      end
      B_FIX: begin
        if (largest != '0) begin
          state_next = B_SEARCH;
        end else if (slot_free) begin
          state_next = B_IDLE;
        end
      end
      B_SEARCH: begin
        if (hit && slot_free) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    started_next       = started;
    first_next         = first;
    cursor_next        = cursor;
    cw_next            = cw;
    divisor_next       = divisor;
    largest_next       = largest;
    scan_idx_next      = scan_idx;
    pick_valid_next    = pick_valid && !pick_ready;
    server_index_next  = server_index;
    none_eligible_next = none_eligible;
    q_pop              = 1'b0;
    gcd_req.start      = 1'b0;
    gcd_req.a          = divisor;
    gcd_req.b          = scan_w;
    unique case (state)
      B_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.rewind || !started) begin
            started_next  = 1'b0;
            scan_idx_next = '0;
            divisor_next  = '0;
            largest_next  = '0;
          end else begin
            first_next = 1'b0;
          end
        end
      end
      B_SCAN: begin
        if (scan_w != '0) begin
          if (scan_w > largest) begin
            largest_next = scan_w;
          end
          if (divisor == '0) begin
            divisor_next = scan_w;
          end else begin
            gcd_req.start = 1'b1;
          end
        end
        if (!((scan_w != '0) && (divisor != '0)) && !scan_last) begin
          scan_idx_next = scan_idx + IDX_W'(1);
        end
      end
      B_GCD: begin
        if (gcd_rsp.done) begin
          divisor_next = gcd_rsp.result;
          if (!scan_last) begin
            scan_idx_next = scan_idx + IDX_W'(1);
          end
        end
      end
      B_FIX: begin
        if (largest != '0) begin
          cw_next     = '0;
          cursor_next = '0;
          first_next  = 1'b1;
        end else if (slot_free) begin
          pick_valid_next    = 1'b1;
          server_index_next  = '0;
          none_eligible_next = 1'b1;
        end
      end
      B_SEARCH: begin
        if (!hit || slot_free) begin
          cursor_next = s_step;
          cw_next     = cw_step;
          first_next  = 1'b0;
        end
        if (hit && slot_free) begin
          started_next       = 1'b1;
          pick_valid_next    = 1'b1;
          server_index_next  = INDEX_W'(s_step);
          none_eligible_next = 1'b0;
        end
      end
      default: begin
        started_next = 1'b0;
      end
    endcase
    if (cfg_touch) begin
      started_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      started    <= 1'b0;
      first      <= 1'b0;
      cursor     <= '0;
      cw         <= '0;
      divisor    <= WEIGHT_BITS'(1);
      largest    <= '0;
      pick_valid <= 1'b0;
    end else begin
      state      <= state_next;
      started    <= started_next;
      first      <= first_next;
      cursor     <= cursor_next;
      cw         <= cw_next;
      divisor    <= divisor_next;
      largest    <= largest_next;
      pick_valid <= pick_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx      <= scan_idx_next;
    server_index  <= server_index_next;
    none_eligible <= none_eligible_next;
  end

endmodule
`default_nettype wire

// ----- rtl/weighted_round_robin_picker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_round_robin_picker
// Interleaved weighted round-robin picker with a register port for the
// server count and the packed weights.
//
//   Channel   Handshake              Word
//   request   req_valid/req_ready    restart
//   pick      pick_valid/pick_ready  server_index, none_eligible
//   config    psel/penable/pready    paddr, pwdata, prdata (64 bits)
//
// A pick in sequence leaves the queue, then the cursor visits one server
// after another until it finds one whose weight reaches the current weight.
// The first pick after reset, a register write or a restart first walks the
// pool once, and each positive weight after the first also runs the divisor
// unit. Requests queue two deep, and the result register lets a new pick
// start while the previous word waits to be taken.
// ----------------------------------------------------------------------------
module weighted_round_robin_picker import wrrp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic               restart,
  output logic               pick_valid,
  input  logic               pick_ready,
  output logic [INDEX_W-1:0] server_index,
  output logic               none_eligible
);

  logic [COUNT_W-1:0] server_count;
  logic [WORD_W-1:0]  weight_word;
  logic               cfg_write;
  logic               cfg_touch;
  logic               q_valid;
  q_item_t            q_item;
  logic               q_pop;
  gcd_req_t           gcd_req;
  gcd_rsp_t           gcd_rsp;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_touch = cfg_write;

  always_ff @(posedge clk) begin
    if (rst) begin
      server_count <= COUNT_W'(1);
      weight_word  <= '0;
    end else if (cfg_write) begin
      unique case (paddr[3])
        REG_SERVER_COUNT: server_count <= pwdata[COUNT_W-1:0];
        REG_WEIGHT_WORD:  weight_word  <= pwdata[WORD_W-1:0];
        default:          server_count <= server_count;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      REG_SERVER_COUNT: prdata = DATA_W'(server_count);
      REG_WEIGHT_WORD:  prdata = DATA_W'(weight_word);
      default:          prdata = '0;
    endcase
  end

  wrrp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .restart   (restart),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  wrrp_gcd u_gcd (
    .clk (clk),
    .rst (rst),
    .req (gcd_req),
    .rsp (gcd_rsp)
  );

  wrrp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_touch     (cfg_touch),
    .server_count  (server_count),
    .weight_word   (weight_word),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .gcd_req       (gcd_req),
    .gcd_rsp       (gcd_rsp),
    .pick_valid    (pick_valid),
    .pick_ready    (pick_ready),
    .server_index  (server_index),
    .none_eligible (none_eligible)
  );

`ifndef ASSERT_OFF
  a_none_index_zero: assert property (@(posedge clk) disable iff (rst)
    (pick_valid && none_eligible) |-> (server_index == '0))
    else $error("A word with no eligible server carries a non-zero index.");

  a_index_in_pool: assert property (@(posedge clk) disable iff (rst)
    (pick_valid && !none_eligible) |->
      (CNT_W'(server_index) < pool_size(server_count)))
    else $error("The chosen server lies outside the pool.");

  a_pick_weighted: assert property (@(posedge clk) disable iff (rst)
    (pick_valid && !none_eligible) |->
      (weight_of(weight_word, IDX_W'(server_index)) != '0))
    else $error("A server with zero weight was chosen.");
`endif

endmodule
`default_nettype wire

// ----- tb/wrrp_pick_checker.sv -----
// ----------------------------------------------------------------------------
// wrrp_pick_checker
// Watches the register port and both channels of the weighted round-robin
// picker. It keeps its own copy of the configuration and the pick sequence,
// predicts one pick word per accepted request and compares each accepted pick
// word, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module wrrp_pick_checker import wrrp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  input  logic               pready,
  input  logic               req_valid,
  input  logic               req_ready,
  input  logic               restart,
  input  logic               pick_valid,
  input  logic               pick_ready,
  input  logic [INDEX_W-1:0] server_index,
  input  logic               none_eligible,
  output int                 fail_count,
  output int                 outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ADDR_W-1:0] SERVER_COUNT_ADDR = ADDR_W'(8 * int'(REG_SERVER_COUNT));
  localparam logic [ADDR_W-1:0] WEIGHT_WORD_ADDR  = ADDR_W'(8 * int'(REG_WEIGHT_WORD));
  localparam int SEARCH_STEPS = ((1 << WEIGHT_BITS) + 2) * MAX_SERVERS;

  typedef struct packed {
    logic [INDEX_W-1:0] server_index;
    logic               none_eligible;
  } pick_t;

  pick_t expected_picks[$];
  pick_t predicted;
  pick_t oldest;

  logic [COUNT_W-1:0]     cfg_count;
  logic [WORD_W-1:0]      cfg_weights;
  logic [INDEX_W-1:0]     cursor_q;
  logic                   started_q;
  logic [CW_W-1:0]        cur_weight_q;
  logic [WEIGHT_BITS-1:0] divisor_q;
  logic [WEIGHT_BITS-1:0] largest_q;

  function automatic int active_servers(input logic [COUNT_W-1:0] sc);
    int n;
    n = int'(sc);
    if (n == 0) n = 1;
    if (n > MAX_SERVERS) n = MAX_SERVERS;
    return n;
  endfunction

  function automatic int weight_at(input logic [WORD_W-1:0] word, input int i);
    logic [WORD_W-1:0] field_mask;
    field_mask = (WORD_W'(1) << WEIGHT_BITS) - WORD_W'(1);
    if (i * WEIGHT_BITS >= WORD_W) return 0;
    return int'((word >> (i * WEIGHT_BITS)) & field_mask);
  endfunction

  function automatic int euclid(input int a, input int b);
    int r;
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  task automatic predict_pick(input logic rewind, output pick_t p);
    int  n;
    int  s;
    int  cw;
    int  w;
    int  g;
    int  m;
    bit  first;
    n = active_servers(cfg_count);
    p.server_index  = '0;
    p.none_eligible = 1'b1;
    if (rewind) started_q = 1'b0;
    first = !started_q;
    if (first) begin
      g = 0;
      m = 0;
      for (int i = 0; i < n; i++) begin
        w = weight_at(cfg_weights, i);
        if (w > 0) begin
          g = (g == 0) ? w : euclid(g, w);
          if (w > m) m = w;
        end
      end
      divisor_q = (g != 0) ? WEIGHT_BITS'(g) : WEIGHT_BITS'(1);
      largest_q = WEIGHT_BITS'(m);
      if (m == 0) return;
      cur_weight_q = '0;
      cursor_q     = '0;
    end
    cw = int'(cur_weight_q);
    s  = int'(cursor_q);
    for (int k = 0; k < SEARCH_STEPS; k++) begin
      if (first) begin
        s = 0;
        first = 1'b0;
      end else begin
        s++;
        if (s >= n) s = 0;
      end
      if (s == 0) begin
        cw -= int'(divisor_q);
        if (cw <= 0) cw = int'(largest_q);
      end
      if (weight_at(cfg_weights, s) >= cw && cw > 0) begin
        cursor_q        = INDEX_W'(s);
        cur_weight_q    = CW_W'(cw);
        started_q       = 1'b1;
        p.server_index  = INDEX_W'(s);
        p.none_eligible = 1'b0;
        return;
      end
    end
    started_q = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg_count    = COUNT_W'(1);
      cfg_weights  = '0;
      cursor_q     = '0;
      started_q    = 1'b0;
      cur_weight_q = '0;
      divisor_q    = WEIGHT_BITS'(1);
      largest_q    = '0;
      fail_count   = 0;
      expected_picks.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == SERVER_COUNT_ADDR) begin
          cfg_count = pwdata[COUNT_W-1:0];
          started_q = 1'b0;
        end else if (paddr == WEIGHT_WORD_ADDR) begin
          cfg_weights = pwdata[WORD_W-1:0];
          started_q   = 1'b0;
        end
      end
      if (req_valid && req_ready) begin
        predict_pick(restart, predicted);
        expected_picks.push_back(predicted);
      end
      if (pick_valid && pick_ready) begin
        if (expected_picks.size() == 0) begin
          $display("%0t: unexpected pick word, server_index %0d none_eligible %0b",
                   $time, server_index, none_eligible);
          fail_count++;
        end else begin
          oldest = expected_picks.pop_front();
          if (server_index !== oldest.server_index) begin
            $display("%0t: server_index expected %0d, actual %0d",
                     $time, oldest.server_index, server_index);
            fail_count++;
          end
          if (none_eligible !== oldest.none_eligible) begin
            $display("%0t: none_eligible expected %0b, actual %0b",
                     $time, oldest.none_eligible, none_eligible);
            fail_count++;
          end
        end
      end
    end
    outstanding = expected_picks.size();
  end

endmodule

// ----- tb/weighted_round_robin_picker_test.sv -----
// ----------------------------------------------------------------------------
// weighted_round_robin_picker_test
// Drives the weighted round-robin picker through a directed set of pool
// configurations and then many random ones, with random idling on both
// channels, and gives the verdict from the checker's failure and outstanding counts.
// ----------------------------------------------------------------------------
module weighted_round_robin_picker_test import wrrp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ADDR_W-1:0] SERVER_COUNT_ADDR = ADDR_W'(8 * int'(REG_SERVER_COUNT));
  localparam logic [ADDR_W-1:0] WEIGHT_WORD_ADDR  = ADDR_W'(8 * int'(REG_WEIGHT_WORD));
  localparam int STALL_LIMIT   = 20000;
  localparam int RANDOM_PHASES = 16;

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  logic               req_valid;
  logic               req_ready;
  logic               restart;
  logic               pick_valid;
  logic               pick_ready;
  logic [INDEX_W-1:0] server_index;
  logic               none_eligible;

  int fail_count;
  int outstanding;
  int idle_pct;
  int ready_hold;
  int idle_cycles;
  bit calm;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  weighted_round_robin_picker DUT (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .restart       (restart),
    .pick_valid    (pick_valid),
    .pick_ready    (pick_ready),
    .server_index  (server_index),
    .none_eligible (none_eligible)
  );

  wrrp_pick_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .restart       (restart),
    .pick_valid    (pick_valid),
    .pick_ready    (pick_ready),
    .server_index  (server_index),
    .none_eligible (none_eligible),
    .fail_count    (fail_count),
    .outstanding   (outstanding)
  );

  always @(negedge clk) begin
    if (calm) begin
      pick_ready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      pick_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      ready_hold <= $urandom_range(0, 6);
      pick_ready <= 1'b0;
    end else begin
      pick_ready <= 1'b1;
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && req_ready) || (pick_valid && pick_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [WORD_W-1:0] random_weights();
    logic [WORD_W-1:0] word;
    int                mode;
    mode = $urandom_range(0, 11);
    if (mode == 0) return '0;
    if (mode == 1) return {$urandom, $urandom};
    word = '0;
    for (int b = 0; b < MAX_SERVERS; b++) begin
      mode = $urandom_range(0, 9);
      if (mode < 3) begin
        word[b*WEIGHT_BITS +: WEIGHT_BITS] = '0;
      end else if (mode < 8) begin
        word[b*WEIGHT_BITS +: WEIGHT_BITS] = WEIGHT_BITS'($urandom_range(1, 12));
      end else begin
        word[b*WEIGHT_BITS +: WEIGHT_BITS] = WEIGHT_BITS'($urandom_range(0, 255));
      end
    end
    return word;
  endfunction

  task automatic write_config(input logic [COUNT_W-1:0] count, input logic [WORD_W-1:0] word);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SERVER_COUNT_ADDR;
    pwdata  <= DATA_W'(count);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    penable <= 1'b0;
    paddr   <= WEIGHT_WORD_ADDR;
    pwdata  <= DATA_W'(word);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_request(input logic rewind, input bit drain_first);
    bit gap;
    gap = !calm && ($urandom_range(0, 99) < idle_pct);
    if (gap || (drain_first && outstanding != 0)) begin
      req_valid <= 1'b0;
      if (gap) repeat ($urandom_range(1, 7)) @(negedge clk);
      while (drain_first && outstanding != 0) @(negedge clk);
    end
    req_valid <= 1'b1;
    restart   <= rewind;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
  endtask

  task automatic run_phase(input logic [COUNT_W-1:0] count, input logic [WORD_W-1:0] word,
                           input int items, input int restart_pct, input bit drain_mid);
    while (outstanding != 0) @(negedge clk);
    write_config(count, word);
    for (int i = 0; i < items; i++) begin
      send_request($urandom_range(0, 99) < restart_pct, drain_mid && (i == items / 2));
    end
    req_valid <= 1'b0;
  endtask

  initial begin
    rst        = 1'b1;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    req_valid  = 1'b0;
    restart    = 1'b0;
    pick_ready = 1'b0;
    ready_hold = 0;
    idle_pct   = 20;
    calm       = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Straight after reset the pool is one server with weight zero.
    send_request(1'b0, 1'b0);
    req_valid <= 1'b0;

    run_phase(COUNT_W'(8), '1, 8, 0, 1'b0);
    run_phase(COUNT_W'(0), WORD_W'(64'h0000_0000_0000_0005), 2, 0, 1'b0);
    run_phase(COUNT_W'(15), WORD_W'(64'h0102_0304_0506_0708), 6, 50, 1'b0);
    run_phase(COUNT_W'(8), '0, 1, 0, 1'b0);
    run_phase(COUNT_W'(3), WORD_W'(64'h0000_0000_0000_0604), 4, 0, 1'b0);
    // The first positive weight is not server 0, so it seeds the divisor.
    run_phase(COUNT_W'(4), WORD_W'(64'h0000_0000_0009_0600), 3, 0, 1'b0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      calm = (p >= RANDOM_PHASES - 2);
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 10;
        default: idle_pct = 30;
      endcase
      if (calm) idle_pct = 0;
      run_phase(COUNT_W'($urandom_range(0, 15)), random_weights(),
                $urandom_range(40, 60), 8, 1'b1);
    end

    while (outstanding != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
